// ----- rtl/core/hsv_pkg.sv -----
// shared widths, constants and pipeline types for the rgb to hsv converter
`timescale 1ns / 1ps

package hsv_pkg;

    localparam int CH_W  = 8;   // one color channel
    localparam int HUE_W = 16;  // hue result
    localparam int HQ_W  = 13;  // hue sector term quotient, at most 7680
    localparam int SQ_W  = 8;   // saturation quotient, at most 255
    localparam int HN_W  = 22;  // hue dividend 2*7680*|diff| + delta
    localparam int SN_W  = 17;  // saturation dividend 2*255*delta + max
    localparam int DEN_W = 9;   // doubled 8-bit divisor

    localparam logic [HUE_W-1:0] HUE_GREEN = 16'd15360;  // 120 deg in 1/128 deg
    localparam logic [HUE_W-1:0] HUE_BLUE  = 16'd30720;  // 240 deg
    localparam logic [HUE_W-1:0] HUE_FULL  = 16'd46080;  // 360 deg

    localparam logic [HN_W-1:0] HUE_SCALE2 = 22'd15360;  // 2 * 60 deg * 128
    localparam logic [SN_W-1:0] SAT_SCALE2 = 17'd510;    // 2 * 255

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } sector_t;

    // per-pixel side info that rides along the divider
    typedef struct packed {
        sector_t         sec;
        logic            neg;    // sector difference is negative
        logic            grey;   // max equals min
        logic            black;  // max is zero
        logic [CH_W-1:0] val;
    } tag_t;

    // two restoring dividers working side by side
    typedef struct packed {
        logic [HN_W-1:0]  hrem;
        logic [DEN_W-1:0] hden;
        logic [HQ_W-1:0]  hq;
        logic [SN_W-1:0]  srem;
        logic [DEN_W-1:0] sden;
        logic [SQ_W-1:0]  sq;
    } div_t;

    typedef struct packed {
        tag_t tag;
        div_t div;
    } stage_t;

endpackage

// ----- rtl/core/hsv_front.sv -----
// front stages: max/min and sector pick, then dividend and divisor setup
`timescale 1ns / 1ps

module hsv_front (
    input  logic                     aclk,
    input  logic                     en_a,
    input  logic                     en_b,
    input  logic [hsv_pkg::CH_W-1:0] red_in,
    input  logic [hsv_pkg::CH_W-1:0] green_in,
    input  logic [hsv_pkg::CH_W-1:0] blue_in,
    output hsv_pkg::stage_t          stage_reg
);

    hsv_pkg::tag_t           tag_next;
    hsv_pkg::tag_t           tag_a_reg;
    logic [hsv_pkg::CH_W-1:0] adiff_next;
    logic [hsv_pkg::CH_W-1:0] adiff_a_reg;
    logic [hsv_pkg::CH_W-1:0] delta_next;
    logic [hsv_pkg::CH_W-1:0] delta_a_reg;
    hsv_pkg::stage_t          stage_next;

    logic [hsv_pkg::CH_W-1:0] mx;
    logic [hsv_pkg::CH_W-1:0] mn;
    logic [hsv_pkg::CH_W-1:0] op_a;
    logic [hsv_pkg::CH_W-1:0] op_b;

    always_comb begin
        mx = red_in;
        mn = red_in;
        if (green_in > mx) mx = green_in;
        if (blue_in > mx) mx = blue_in;
        if (green_in < mn) mn = green_in;
        if (blue_in < mn) mn = blue_in;

        // red wins ties over green, green over blue
        if (mx == red_in) begin
            tag_next.sec = hsv_pkg::SEC_RED;
            op_a = green_in;
            op_b = blue_in;
        end else if (mx == green_in) begin
            tag_next.sec = hsv_pkg::SEC_GREEN;
            op_a = blue_in;
            op_b = red_in;
        end else begin
            tag_next.sec = hsv_pkg::SEC_BLUE;
            op_a = red_in;
            op_b = green_in;
        end

        tag_next.neg   = (op_a < op_b);
        tag_next.grey  = (mx == mn);
        tag_next.black = (mx == '0);
        tag_next.val   = mx;
        adiff_next     = tag_next.neg ? (op_b - op_a) : (op_a - op_b);
        delta_next     = mx - mn;
    end

    always_ff @(posedge aclk) begin
        if (en_a) begin
            tag_a_reg   <= tag_next;
            adiff_a_reg <= adiff_next;
            delta_a_reg <= delta_next;
        end
    end

    // round to nearest: floor((2n + d) / (2d))
    always_comb begin
        stage_next.tag      = tag_a_reg;
        stage_next.div.hrem = hsv_pkg::HN_W'(adiff_a_reg) * hsv_pkg::HUE_SCALE2
                            + hsv_pkg::HN_W'(delta_a_reg);
        stage_next.div.hden = {delta_a_reg, 1'b0};
        stage_next.div.hq   = '0;
        stage_next.div.srem = hsv_pkg::SN_W'(delta_a_reg) * hsv_pkg::SAT_SCALE2
                            + hsv_pkg::SN_W'(tag_a_reg.val);
        stage_next.div.sden = {tag_a_reg.val, 1'b0};
        stage_next.div.sq   = '0;
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            stage_reg <= stage_next;
        end
    end

endmodule

// ----- rtl/core/hsv_div_step.sv -----
// one divider stage: up to BITS restoring quotient bits for hue and saturation
`timescale 1ns / 1ps

module hsv_div_step #(
    parameter int STEP = 0,
    parameter int BITS = 2
) (
    input  logic            aclk,
    input  logic            en,
    input  hsv_pkg::stage_t stage_in,
    output hsv_pkg::stage_t stage_reg
);

    hsv_pkg::stage_t         stage_next;

    always_comb begin
        int hpos;
        int spos;
        logic [hsv_pkg::HN_W-1:0] hsh;
        logic [hsv_pkg::SN_W-1:0] ssh;

        hsh = '0;
        ssh = '0;
        stage_next = stage_in;
        for (int k = 0; k < BITS; k++) begin
            hpos = hsv_pkg::HQ_W - 1 - STEP * BITS - k;
            spos = hsv_pkg::SQ_W - 1 - STEP * BITS - k;
            if (hpos >= 0) begin
                hsh = hsv_pkg::HN_W'(stage_next.div.hden) << hpos;
                if (stage_next.div.hrem >= hsh) begin
                    stage_next.div.hrem = stage_next.div.hrem - hsh;
                    stage_next.div.hq[hpos[$clog2(hsv_pkg::HQ_W)-1:0]] = 1'b1;
                end
            end
            if (spos >= 0) begin
                ssh = hsv_pkg::SN_W'(stage_next.div.sden) << spos;
                if (stage_next.div.srem >= ssh) begin
                    stage_next.div.srem = stage_next.div.srem - ssh;
                    stage_next.div.sq[spos[$clog2(hsv_pkg::SQ_W)-1:0]] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg <= stage_next;
        end
    end

endmodule

// ----- rtl/core/hsv_finish.sv -----
// last stage: sector offset, sign, wrap and special cases into output registers
`timescale 1ns / 1ps

module hsv_finish (
    input  logic                      aclk,
    input  logic                      en,
    input  hsv_pkg::stage_t           stage_in,
    output logic [hsv_pkg::HUE_W-1:0] hue_reg,
    output logic [hsv_pkg::CH_W-1:0]  sat_reg,
    output logic [hsv_pkg::CH_W-1:0]  val_reg
);

    logic [hsv_pkg::HUE_W-1:0] term;
    logic [hsv_pkg::HUE_W-1:0] hue_next;
    logic [hsv_pkg::CH_W-1:0]  sat_next;

    always_comb begin
        term = hsv_pkg::HUE_W'(stage_in.div.hq);
        if (stage_in.tag.grey) begin
            hue_next = '0;
        end else begin
            case (stage_in.tag.sec)
                hsv_pkg::SEC_RED: begin
                    // negative red hue wraps, unless it rounded to zero
                    if (stage_in.tag.neg && (term != '0)) hue_next = hsv_pkg::HUE_FULL - term;
                    else hue_next = term;
                end
                hsv_pkg::SEC_GREEN: begin
                    hue_next = stage_in.tag.neg ? (hsv_pkg::HUE_GREEN - term)
                                                : (hsv_pkg::HUE_GREEN + term);
                end
                hsv_pkg::SEC_BLUE: begin
                    hue_next = stage_in.tag.neg ? (hsv_pkg::HUE_BLUE - term)
                                                : (hsv_pkg::HUE_BLUE + term);
                end
                default: hue_next = '0;
            endcase
        end
        sat_next = stage_in.tag.black ? '0 : stage_in.div.sq;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            val_reg <= stage_in.tag.val;
        end
    end

endmodule

// ----- rtl/core/rgb_to_hsv_pixel_top.sv -----
// top level of the pipelined rgb to hsv pixel converter
`timescale 1ns / 1ps

// channel   direction  handshake           word
// s_        in         s_valid / s_ready   s_red_in, s_green_in, s_blue_in (8 bit each)
// m_        out        m_valid / m_ready   m_hue_out (16 bit), m_sat_out, m_val_out
//
// one pixel per clock sustained while m_ready stays high; the pipeline depth is set
// by the restoring divider stages of the hue term
// every stage has its own valid bit and loads when it is empty or its word moves on,
// so bubbles are squeezed out and a stall backs up stage by stage
// synchronous active-low reset clears the valid bits only; data registers keep
// garbage until a word lands in them

module rgb_to_hsv_pixel_top #(
    parameter int DIV_BITS = 2  // quotient bits per divider stage, 1 to 13
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [hsv_pkg::CH_W-1:0]  s_red_in,
    input  logic [hsv_pkg::CH_W-1:0]  s_green_in,
    input  logic [hsv_pkg::CH_W-1:0]  s_blue_in,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [hsv_pkg::HUE_W-1:0] m_hue_out,
    output logic [hsv_pkg::CH_W-1:0]  m_sat_out,
    output logic [hsv_pkg::CH_W-1:0]  m_val_out
);

    // two front stages, then the divider stages and one finishing stage
    localparam int DIV_STAGES = (hsv_pkg::HQ_W + DIV_BITS - 1) / DIV_BITS;
    localparam int NUM_STAGES = DIV_STAGES + 3;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES:0]   stage_ready;

    hsv_pkg::stage_t div_pipe [DIV_STAGES+1];

    // a stage may load when it is empty or its word leaves this cycle
    always_comb begin
        stage_ready[NUM_STAGES] = m_ready;
        for (int i = NUM_STAGES - 1; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
    end

    always_comb begin
        valid_next[0] = stage_ready[0] ? s_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++) begin
            valid_next[i] = stage_ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_ready[0];
    assign m_valid = valid_reg[NUM_STAGES-1];

    // max/min, sector and dividend setup
    hsv_front u_front (
        .aclk      (aclk),
        .en_a      (stage_ready[0]),
        .en_b      (stage_ready[1]),
        .red_in    (s_red_in),
        .green_in  (s_green_in),
        .blue_in   (s_blue_in),
        .stage_reg (div_pipe[0])
    );

    // restoring dividers for hue term and saturation, DIV_BITS bits a stage
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        hsv_div_step #(
            .STEP (j),
            .BITS (DIV_BITS)
        ) u_step (
            .aclk      (aclk),
            .en        (stage_ready[j+2]),
            .stage_in  (div_pipe[j]),
            .stage_reg (div_pipe[j+1])
        );
    end

    // sector offset, wrap and output registers
    hsv_finish u_finish (
        .aclk     (aclk),
        .en       (stage_ready[NUM_STAGES-1]),
        .stage_in (div_pipe[DIV_STAGES]),
        .hue_reg  (m_hue_out),
        .sat_reg  (m_sat_out),
        .val_reg  (m_val_out)
    );

    // hue never reaches a full turn
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hue_out < hsv_pkg::HUE_FULL))
        else $error("hue out of range");

    // a black pixel has no saturation and no hue
    a_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_val_out == '0)) |-> ((m_sat_out == '0) && (m_hue_out == '0)))
        else $error("black pixel with nonzero hue or saturation");

    // zero saturation only comes from a grey pixel, whose hue is zero
    a_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_sat_out == '0)) |-> (m_hue_out == '0))
        else $error("zero saturation with nonzero hue");

    // an empty first stage always takes a word
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[0] |-> s_ready)
        else $error("input stalled with empty first stage");

    // reset empties the pipe
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid right after reset");

endmodule
